[src/rgb_to_hsl_converter_assert.svh]
// Assertion macros for the RGB to HSL converter.
// Depends on nothing; included by the top level.
`ifndef RGB_TO_HSL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define RGBHSL_ASSERT_IMP(lbl, clk, rstn, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
		else $error("assertion failed");
// implication after a fixed pipeline latency
`define RGBHSL_ASSERT_LAT(lbl, clk, rstn, a, n, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> ##n (b)) \
		else $error("latency assertion failed");
`else
`define RGBHSL_ASSERT_IMP(lbl, clk, rstn, a, b)
`define RGBHSL_ASSERT_LAT(lbl, clk, rstn, a, n, b)
`endif
`endif

[src/rgbhsl_pkg.sv]
// Types and constants of the RGB to HSL converter.
// Depends on nothing; used by every module of the block.
`default_nettype none
package rgbhsl_pkg;
	localparam int DIV_W      = 11;           // widest divisor: 6 * 255
	localparam int QUO_W      = 17;           // quotient up to 1.0 in Q1.16
	localparam int DIV_STAGES = QUO_W;        // one quotient bit per stage
	localparam int LATENCY    = 3 + DIV_STAGES;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [15:0] hue;
		logic [15:0] saturation;
		logic [8:0]  lightness_sum;
	} hsl_t;

	typedef struct packed {
		logic [DIV_W-1:0] num_hue;
		logic [DIV_W-1:0] den_hue;
		logic [DIV_W-1:0] num_sat;
		logic [DIV_W-1:0] den_sat;
		logic [8:0]       lsum;
		logic             grey;
	} front_t;
endpackage
`default_nettype wire

[src/rgbhsl_front.sv]
// Front end: max/min search, then divider operands for hue and saturation.
// Depends on rgbhsl_pkg.
`default_nettype none
module rgbhsl_front import rgbhsl_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_vld,
	input  wire pixel_t pix,
	output logic        out_vld,
	output front_t      out_op
);
	logic       vld_s1;
	logic [7:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic [7:0] mx_c, mn_c;

	// find the largest and smallest component
	always_comb begin
		mx_c = pix.red;
		mn_c = pix.red;
		if (pix.green > mx_c) mx_c = pix.green;
		if (pix.blue > mx_c) mx_c = pix.blue;
		if (pix.green < mn_c) mn_c = pix.green;
		if (pix.blue < mn_c) mn_c = pix.blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		r_s1  <= pix.red;
		g_s1  <= pix.green;
		b_s1  <= pix.blue;
		mx_s1 <= mx_c;
		mn_s1 <= mn_c;
	end

	// sextant numerator, sum and divisors
	logic [8:0]       sum_c;
	logic [7:0]       d_c;
	logic [DIV_W-1:0] dw_c, num_c, den_sat_c;
	front_t           op_c;

	always_comb begin
		sum_c = {1'b0, mx_s1} + {1'b0, mn_s1};
		d_c   = mx_s1 - mn_s1;
		dw_c  = {{(DIV_W-8){1'b0}}, d_c};
		if (r_s1 == mx_s1) begin
			if (g_s1 == mn_s1)
				num_c = DIV_W'(5) * dw_c + {{(DIV_W-8){1'b0}}, mx_s1 - b_s1};
			else
				num_c = dw_c - {{(DIV_W-8){1'b0}}, mx_s1 - g_s1};
		end else if (g_s1 == mx_s1) begin
			if (b_s1 == mn_s1)
				num_c = dw_c + {{(DIV_W-8){1'b0}}, mx_s1 - r_s1};
			else
				num_c = DIV_W'(3) * dw_c - {{(DIV_W-8){1'b0}}, mx_s1 - b_s1};
		end else begin
			if (r_s1 == mn_s1)
				num_c = DIV_W'(3) * dw_c + {{(DIV_W-8){1'b0}}, mx_s1 - g_s1};
			else
				num_c = DIV_W'(5) * dw_c - {{(DIV_W-8){1'b0}}, mx_s1 - r_s1};
		end
		if (sum_c <= 9'd255)
			den_sat_c = {{(DIV_W-9){1'b0}}, sum_c};
		else
			den_sat_c = {{(DIV_W-9){1'b0}}, 9'd510 - sum_c};
		op_c.num_hue = num_c;
		op_c.den_hue = DIV_W'(6) * dw_c;
		op_c.num_sat = dw_c;
		op_c.den_sat = den_sat_c;
		op_c.lsum    = sum_c;
		op_c.grey    = (d_c == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_op <= op_c;
	end
endmodule
`default_nettype wire

[src/rgbhsl_div.sv]
// Pipelined restoring divider: quotient floor(num * 2^16 / den), one bit a stage.
// Depends on rgbhsl_pkg; requires num <= den.
`default_nettype none
module rgbhsl_div import rgbhsl_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_vld,
	input  wire logic [DIV_W-1:0] num,
	input  wire logic [DIV_W-1:0] den,
	output logic                  out_vld,
	output logic [QUO_W-1:0]      quo
);
	logic             vld_s [DIV_STAGES];
	logic [DIV_W-1:0] rem_s [DIV_STAGES];
	logic [DIV_W-1:0] den_s [DIV_STAGES];
	logic [QUO_W-1:0] quo_s [DIV_STAGES];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			for (int i = 1; i < DIV_STAGES; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// first stage settles the integer bit, the rest one fraction bit each
	always_ff @(posedge clk) begin
		logic [DIV_W:0] sh;
		if (num >= den) begin
			rem_s[0] <= num - den;
			quo_s[0] <= {{(QUO_W-1){1'b0}}, 1'b1};
		end else begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
		end
		den_s[0] <= den;
		for (int i = 1; i < DIV_STAGES; i++) begin
			sh = {rem_s[i-1], 1'b0};
			if (sh >= {1'b0, den_s[i-1]}) begin
				rem_s[i] <= DIV_W'(sh - {1'b0, den_s[i-1]});
				quo_s[i] <= {quo_s[i-1][QUO_W-2:0], 1'b1};
			end else begin
				rem_s[i] <= sh[DIV_W-1:0];
				quo_s[i] <= {quo_s[i-1][QUO_W-2:0], 1'b0};
			end
			den_s[i] <= den_s[i-1];
		end
	end

	assign out_vld = vld_s[DIV_STAGES-1];
	assign quo     = quo_s[DIV_STAGES-1];
endmodule
`default_nettype wire

[src/rgb_to_hsl_converter.sv]
// Top level of the RGB to HSL converter: front end, two dividers, output register.
// Depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_div and the assertion header.
//
//  channel | ports               | beat
//  pixel   | start, busy, pixel  | start high and busy low at a clock edge
//  result  | done, result        | done high for one cycle
//
// A pixel enters every cycle; its result passes the 17-stage divider (one
// quotient bit per stage) plus three other stages before done rises.
// busy is always low: the pipeline never stalls and the receiver cannot.
// Reset clears the valid bits only; no stored state besides.
`default_nettype none
`include "rgb_to_hsl_converter_assert.svh"
module rgb_to_hsl_converter import rgbhsl_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	output logic        busy,
	input  wire pixel_t pixel,
	output logic        done,
	output hsl_t        result
);
	logic   fr_vld;
	front_t fr_op;
	logic   hue_vld, sat_vld;
	logic [QUO_W-1:0] hue_quo, sat_quo;

	assign busy = 1'b0;

	rgbhsl_front u_front (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy), .pix(pixel),
		.out_vld(fr_vld), .out_op(fr_op)
	);

	rgbhsl_div u_div_hue (
		.clk(clk), .arst_n(arst_n), .in_vld(fr_vld),
		.num(fr_op.num_hue), .den(fr_op.den_hue),
		.out_vld(hue_vld), .quo(hue_quo)
	);

	rgbhsl_div u_div_sat (
		.clk(clk), .arst_n(arst_n), .in_vld(fr_vld),
		.num(fr_op.num_sat), .den(fr_op.den_sat),
		.out_vld(sat_vld), .quo(sat_quo)
	);

	// delay lightness and grey flag alongside the dividers
	logic [8:0] lsum_sd [DIV_STAGES];
	logic       grey_sd [DIV_STAGES];

	always_ff @(posedge clk) begin
		lsum_sd[0] <= fr_op.lsum;
		grey_sd[0] <= fr_op.grey;
		for (int i = 1; i < DIV_STAGES; i++) begin
			lsum_sd[i] <= lsum_sd[i-1];
			grey_sd[i] <= grey_sd[i-1];
		end
	end

	// hue wraps past a full turn, saturation clamps at one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= hue_vld;
		end
	end

	always_ff @(posedge clk) begin
		result.lightness_sum <= lsum_sd[DIV_STAGES-1];
		if (grey_sd[DIV_STAGES-1]) begin
			result.hue        <= '0;
			result.saturation <= '0;
		end else begin
			result.hue        <= hue_quo[15:0];
			result.saturation <= sat_quo[QUO_W-1] ? 16'hFFFF : sat_quo[15:0];
		end
	end

	`RGBHSL_ASSERT_LAT(a_latency, clk, arst_n, start && !busy, 20, done)
	`RGBHSL_ASSERT_IMP(a_div_sync, clk, arst_n, hue_vld || sat_vld, hue_vld && sat_vld)
	`RGBHSL_ASSERT_IMP(a_black, clk, arst_n, done && result.lightness_sum == 9'd0,
		result.hue == 16'd0 && result.saturation == 16'd0)
endmodule
`default_nettype wire

[dv/rgb_to_hsl_converter_check.sv]
// Checker for the RGB to HSL converter: predicts each result from the pixel beat.
// Depends on rgbhsl_pkg; instantiated beside the block by the testbench top.
module rgb_to_hsl_converter_check import rgbhsl_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire logic   busy,
	input  wire pixel_t pixel,
	input  wire logic   done,
	input  wire hsl_t   result,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	hsl_t hsl_queue[$];
	int   mismatch_count = 0;
	int   extra_count = 0;

	// compute hue, saturation and lightness sum of one pixel
	function automatic hsl_t convert_pixel(pixel_t px);
		logic [31:0] r, g, b, mx, mn, d, sum, den, sat, num, hue;
		hsl_t res;
		r = 32'(px.red);
		g = 32'(px.green);
		b = 32'(px.blue);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		sum = mx + mn;
		d = mx - mn;
		hue = 0;
		sat = 0;
		if (d != 0) begin
			den = (sum <= 255) ? sum : (510 - sum);
			sat = (d << 16) / den;
			if (sat > 65535) sat = 65535;
			if (r == mx)
				num = (g == mn) ? (5 * d + (mx - b)) : (d - (mx - g));
			else if (g == mx)
				num = (b == mn) ? (d + (mx - r)) : (3 * d - (mx - b));
			else
				num = (r == mn) ? (3 * d + (mx - g)) : (5 * d - (mx - r));
			hue = (num << 16) / (6 * d);
		end
		res.hue = hue[15:0];
		res.saturation = sat[15:0];
		res.lightness_sum = sum[8:0];
		return res;
	endfunction

	assign fail_count = mismatch_count + extra_count;
	assign pending = hsl_queue.size();

	// record expectations and compare results on each edge
	always @(posedge clk) begin
		hsl_t exp_hsl;
		if (arst_n) begin
			if (start && !busy)
				hsl_queue.push_back(convert_pixel(pixel));
			if (done) begin
				if (hsl_queue.size() == 0) begin
					extra_count++;
					if (mismatch_count + extra_count <= 10)
						$display("unexpected result %h", result);
				end else begin
					exp_hsl = hsl_queue.pop_front();
					if (result !== exp_hsl) begin
						mismatch_count++;
						if (mismatch_count + extra_count <= 10)
							$display("result mismatch: exp h=%0d s=%0d l=%0d got h=%0d s=%0d l=%0d",
								exp_hsl.hue, exp_hsl.saturation, exp_hsl.lightness_sum,
								result.hue, result.saturation, result.lightness_sum);
					end
				end
			end
		end
	end
endmodule

[dv/rgb_to_hsl_converter_test.sv]
// Testbench top for the RGB to HSL converter: drives pixel beats, gives the verdict.
// Depends on rgbhsl_pkg, rgb_to_hsl_converter and rgb_to_hsl_converter_check.
module rgb_to_hsl_converter_test;
	import rgbhsl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20 * LATENCY + 200;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	pixel_t pixel = '0;
	logic   busy;
	logic   done;
	hsl_t   result;
	int     fail_count;
	int     pending;
	int     idle_cycles = 0;
	int     pixel_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rgb_to_hsl_converter i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel(pixel), .done(done), .result(result)
	);

	rgb_to_hsl_converter_check i_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.done(done), .result(result), .fail_count(fail_count), .pending(pending)
	);

	// stop the run when nothing is accepted or done for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// send one pixel beat, then wait a random gap
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		start <= 1'b1;
		pixel <= '{red: r, green: g, blue: b};
		@(posedge clk);
		while (busy) @(posedge clk);
		pixel_count++;
		gap = ($urandom_range(0, 3) == 0) ?
			(($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3)) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// pick a component, often an extreme or a repeat of another
	function automatic logic [7:0] pick_level(logic [7:0] other);
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return other;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		logic [7:0] r, g, b;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: grey, primaries, secondaries, ties and each sextant
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd200, 8'd10, 8'd100);
		send_pixel(8'd200, 8'd100, 8'd10);
		send_pixel(8'd100, 8'd200, 8'd10);
		send_pixel(8'd10, 8'd200, 8'd100);
		send_pixel(8'd10, 8'd100, 8'd200);
		send_pixel(8'd100, 8'd10, 8'd200);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd128, 8'd127, 8'd127);
		send_pixel(8'd127, 8'd128, 8'd128);
		send_pixel(8'd170, 8'd85, 8'd85);
		// hold until the pipeline drains
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// random pixels, some runs back to back
		repeat (800) begin
			r = 8'($urandom_range(0, 255));
			g = pick_level(r);
			b = pick_level($urandom_range(0, 1) ? r : g);
			send_pixel(r, g, b);
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("Sent %0d pixels: grey, primary, tie and all six hue sextants, random gaps.",
			pixel_count);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
